// ===== hdl/ole_pkg.sv =====
package ole_pkg;

  localparam int unsigned CAPACITY_DEF      = 256;
  localparam int unsigned ELEMENT_WIDTH_DEF = 32;

  localparam int unsigned KIND_W   = 3;
  localparam int unsigned POS_W    = 9;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned INDEX_W  = 9;
  localparam int unsigned COUNT_W  = 9;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT,
    KIND_REMOVE,
    KIND_GET,
    KIND_FIND,
    KIND_FIRST,
    KIND_LAST,
    KIND_CLEAR,
    KIND_NONE
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK,
    ST_FULL,
    ST_BADPOS,
    ST_EMPTY
  } status_e;

  typedef struct packed {
    logic cap;
    logic issue;
    logic take;
    logic up_step;
    logic ins_write;
    logic down_step;
    logic rm_done;
    logic find_step;
  } dp_cmd_t;

  typedef struct packed {
    logic imm;
    logic more_up;
    logic more_down;
    logic find_hit;
    logic find_end;
  } dp_stat_t;

endpackage

// ===== hdl/ole_ram.sv =====
module ole_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/ole_ctrl.sv =====
module ole_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [ole_pkg::KIND_W-1:0]   kind_i,
  input  ole_pkg::dp_stat_t            stat_i,
  output ole_pkg::dp_cmd_t             cmd_o,
  output logic                         busy_o,
  output logic                         done_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_TAKE,
    S_UP,
    S_INS,
    S_DOWN,
    S_FIND
  } state_e;

  state_e               state_q;
  logic                 done_q;
  ole_pkg::kind_e       kind_q;

  always_comb begin
    cmd_o = '0;
    case (state_q)
      S_IDLE: cmd_o.cap = start_i;
      S_READ: cmd_o.issue = 1'b1;
      S_TAKE: cmd_o.take = 1'b1;
      S_UP:   cmd_o.up_step = 1'b1;
      S_INS:  cmd_o.ins_write = 1'b1;
      S_DOWN: begin
        cmd_o.down_step = 1'b1;
        cmd_o.rm_done   = !stat_i.more_down;
      end
      S_FIND: cmd_o.find_step = 1'b1;
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
      kind_q  <= ole_pkg::KIND_NONE;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            kind_q <= ole_pkg::kind_e'(kind_i);
            if (stat_i.imm) begin
              done_q <= 1'b1;
            end else begin
              case (ole_pkg::kind_e'(kind_i))
                ole_pkg::KIND_INSERT: state_q <= S_UP;
                ole_pkg::KIND_FIND:   state_q <= S_FIND;
                default:              state_q <= S_READ;
              endcase
            end
          end
        end
        S_READ: state_q <= S_TAKE;
        S_TAKE: begin
          if (kind_q == ole_pkg::KIND_REMOVE) begin
            state_q <= S_DOWN;
          end else begin
            state_q <= S_IDLE;
            done_q  <= 1'b1;
          end
        end
        S_UP: begin
          if (!stat_i.more_up) begin
            state_q <= S_INS;
          end
        end
        S_INS: begin
          state_q <= S_IDLE;
          done_q  <= 1'b1;
        end
        S_DOWN: begin
          if (!stat_i.more_down) begin
            state_q <= S_IDLE;
            done_q  <= 1'b1;
          end
        end
        S_FIND: begin
          if (stat_i.find_hit || stat_i.find_end) begin
            state_q <= S_IDLE;
            done_q  <= 1'b1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule

// ===== hdl/ole_dp.sv =====
module ole_dp #(
  parameter int unsigned CAPACITY      = ole_pkg::CAPACITY_DEF,
  parameter int unsigned ELEMENT_WIDTH = ole_pkg::ELEMENT_WIDTH_DEF
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  ole_pkg::dp_cmd_t                          cmd_i,
  output ole_pkg::dp_stat_t                         stat_o,
  input  logic [ole_pkg::KIND_W-1:0]                kind_i,
  input  logic [ole_pkg::POS_W-1:0]                 position_i,
  input  logic [ole_pkg::VALUE_W-1:0]               value_i,
  output logic                                      ram_we_o,
  output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] ram_waddr_o,
  output logic [ELEMENT_WIDTH-1:0]                  ram_wdata_o,
  output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] ram_raddr_o,
  input  logic [ELEMENT_WIDTH-1:0]                  ram_rdata_i,
  output logic [ole_pkg::STATUS_W-1:0]              status_o,
  output logic [ole_pkg::VALUE_W-1:0]               element_o,
  output logic signed [ole_pkg::INDEX_W-1:0]        found_index_o,
  output logic [ole_pkg::COUNT_W-1:0]               count_o
);

  localparam int unsigned AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned CMPW = (CW > ole_pkg::POS_W) ? CW : ole_pkg::POS_W;

  logic [CW-1:0]                    cnt_q;
  logic [CW-1:0]                    ptr_q;
  logic [CMPW-1:0]                  pos_q;
  logic [ELEMENT_WIDTH-1:0]         val_q;
  logic                             wr_pend_q;
  logic [AW-1:0]                    wr_addr_q;
  logic                             cmp_pend_q;
  logic [AW-1:0]                    cmp_idx_q;
  ole_pkg::status_e                 status_q;
  logic [ole_pkg::VALUE_W-1:0]      elem_q;
  logic [ole_pkg::INDEX_W-1:0]      fidx_q;

  logic [CMPW-1:0]                  pos_x;
  logic [CMPW-1:0]                  cnt_x;
  logic                             imm;
  ole_pkg::status_e                 imm_st;
  logic [CW-1:0]                    ptr_init;
  logic [CW-1:0]                    ptr_m1;
  logic [CW-1:0]                    ptr_p1;
  logic                             more_up;
  logic                             more_down;
  logic                             scan_more;
  logic                             hit;

  assign pos_x  = CMPW'(position_i);
  assign cnt_x  = CMPW'(cnt_q);
  assign ptr_m1 = ptr_q - CW'(1);
  assign ptr_p1 = ptr_q + CW'(1);

  always_comb begin
    imm      = 1'b0;
    imm_st   = ole_pkg::ST_OK;
    ptr_init = '0;
    case (ole_pkg::kind_e'(kind_i))
      ole_pkg::KIND_INSERT: begin
        ptr_init = cnt_q;
        if (cnt_q == CW'(CAPACITY)) begin
          imm    = 1'b1;
          imm_st = ole_pkg::ST_FULL;
        end else if (pos_x > cnt_x) begin
          imm    = 1'b1;
          imm_st = ole_pkg::ST_BADPOS;
        end
      end
      ole_pkg::KIND_REMOVE, ole_pkg::KIND_GET: begin
        ptr_init = CW'(position_i);
        if (cnt_q == '0) begin
          imm    = 1'b1;
          imm_st = ole_pkg::ST_EMPTY;
        end else if (pos_x >= cnt_x) begin
          imm    = 1'b1;
          imm_st = ole_pkg::ST_BADPOS;
        end
      end
      ole_pkg::KIND_FIRST, ole_pkg::KIND_LAST: begin
        if (ole_pkg::kind_e'(kind_i) == ole_pkg::KIND_LAST) begin
          ptr_init = cnt_q - CW'(1);
        end
        if (cnt_q == '0) begin
          imm    = 1'b1;
          imm_st = ole_pkg::ST_EMPTY;
        end
      end
      ole_pkg::KIND_CLEAR, ole_pkg::KIND_NONE: imm = 1'b1;
      default: imm = 1'b0;
    endcase
  end

  assign more_up   = (CMPW'(ptr_q) > pos_q);
  assign more_down = ({1'b0, ptr_q} + (CW + 1)'(1)) < {1'b0, cnt_q};
  assign scan_more = (ptr_q < cnt_q);
  assign hit       = cmp_pend_q && (ram_rdata_i == val_q);

  assign stat_o.imm       = imm;
  assign stat_o.more_up   = more_up;
  assign stat_o.more_down = more_down;
  assign stat_o.find_hit  = hit;
  assign stat_o.find_end  = !cmp_pend_q && !scan_more;

  always_comb begin
    ram_raddr_o = ptr_q[AW-1:0];
    if (cmd_i.up_step) begin
      ram_raddr_o = ptr_m1[AW-1:0];
    end else if (cmd_i.down_step) begin
      ram_raddr_o = ptr_p1[AW-1:0];
    end
  end

  assign ram_we_o    = cmd_i.ins_write || wr_pend_q;
  assign ram_waddr_o = cmd_i.ins_write ? pos_q[AW-1:0] : wr_addr_q;
  assign ram_wdata_o = cmd_i.ins_write ? val_q : ram_rdata_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      wr_pend_q  <= 1'b0;
      cmp_pend_q <= 1'b0;
    end else begin
      if (cmd_i.cap) begin
        wr_pend_q  <= 1'b0;
        cmp_pend_q <= 1'b0;
        if (ole_pkg::kind_e'(kind_i) == ole_pkg::KIND_CLEAR) begin
          cnt_q <= '0;
        end
      end
      if (cmd_i.up_step || cmd_i.down_step) begin
        wr_pend_q <= cmd_i.up_step ? more_up : more_down;
      end
      if (cmd_i.ins_write) begin
        cnt_q <= cnt_q + CW'(1);
      end
      if (cmd_i.rm_done) begin
        cnt_q <= cnt_q - CW'(1);
      end
      if (cmd_i.find_step) begin
        cmp_pend_q <= scan_more && !hit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      ptr_q <= ptr_init;
      pos_q <= pos_x;
      val_q <= ELEMENT_WIDTH'(value_i);
      if (imm) begin
        status_q <= imm_st;
        elem_q   <= '0;
        fidx_q   <= '0;
      end
    end
    if (cmd_i.take) begin
      status_q <= ole_pkg::ST_OK;
      elem_q   <= ole_pkg::VALUE_W'(ram_rdata_i);
      fidx_q   <= '0;
    end
    if (cmd_i.up_step && more_up) begin
      ptr_q     <= ptr_m1;
      wr_addr_q <= ptr_q[AW-1:0];
    end
    if (cmd_i.down_step && more_down) begin
      ptr_q     <= ptr_p1;
      wr_addr_q <= ptr_q[AW-1:0];
    end
    if (cmd_i.ins_write) begin
      status_q <= ole_pkg::ST_OK;
      elem_q   <= '0;
      fidx_q   <= '0;
    end
    if (cmd_i.find_step) begin
      if (scan_more && !hit) begin
        ptr_q     <= ptr_p1;
        cmp_idx_q <= ptr_q[AW-1:0];
      end
      if (hit) begin
        status_q <= ole_pkg::ST_OK;
        elem_q   <= '0;
        fidx_q   <= ole_pkg::INDEX_W'(cmp_idx_q);
      end else if (!cmp_pend_q && !scan_more) begin
        status_q <= ole_pkg::ST_EMPTY;
        elem_q   <= '0;
        fidx_q   <= '1;
      end
    end
  end

  assign status_o      = status_q;
  assign element_o     = elem_q;
  assign found_index_o = $signed(fidx_q);
  assign count_o       = ole_pkg::COUNT_W'(cnt_q);

endmodule

// ===== hdl/ordered_list_engine.sv =====
// A result word appears in the cycle after acceptance for errors, clear and kind seven.
// Get, first and last pass through a read state and a take state, as the list memory read is registered.
// Insert and remove shift the entries between the position and the list end, one entry moved per cycle.
// Find scans the list from index zero and stops at the first hit or at the end of the list.
// Busy is low while done_o shows a result, and one request completes before the next is taken.
// Reset clears the count and the control state; the list memory is not cleared.
module ordered_list_engine #(
  parameter int unsigned CAPACITY      = ole_pkg::CAPACITY_DEF,
  parameter int unsigned ELEMENT_WIDTH = ole_pkg::ELEMENT_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [ole_pkg::KIND_W-1:0]          kind_i,
  input  logic [ole_pkg::POS_W-1:0]           position_i,
  input  logic [ole_pkg::VALUE_W-1:0]         value_i,
  output logic                                done_o,
  output logic [ole_pkg::STATUS_W-1:0]        status_o,
  output logic [ole_pkg::VALUE_W-1:0]         element_o,
  output logic signed [ole_pkg::INDEX_W-1:0]  found_index_o,
  output logic [ole_pkg::COUNT_W-1:0]         count_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  ole_pkg::dp_cmd_t           cmd;
  ole_pkg::dp_stat_t          stat;
  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic [ELEMENT_WIDTH-1:0]   ram_wdata;
  logic [AW-1:0]              ram_raddr;
  logic [ELEMENT_WIDTH-1:0]   ram_rdata;

  ole_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .kind_i  (kind_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  ole_dp #(
    .CAPACITY      (CAPACITY),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .kind_i        (kind_i),
    .position_i    (position_i),
    .value_i       (value_i),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata),
    .ram_raddr_o   (ram_raddr),
    .ram_rdata_i   (ram_rdata),
    .status_o      (status_o),
    .element_o     (element_o),
    .found_index_o (found_index_o),
    .count_o       (count_o)
  );

  ole_ram #(
    .WIDTH (ELEMENT_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

// ===== hdl/ole_checker.sv =====
module ole_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                start,
  input logic                                busy,
  input logic [ole_pkg::KIND_W-1:0]          kind_i,
  input logic [ole_pkg::POS_W-1:0]           position_i,
  input logic [ole_pkg::VALUE_W-1:0]         value_i,
  input logic                                done_o,
  input logic [ole_pkg::STATUS_W-1:0]        status_o,
  input logic [ole_pkg::VALUE_W-1:0]         element_o,
  input logic signed [ole_pkg::INDEX_W-1:0]  found_index_o,
  input logic [ole_pkg::COUNT_W-1:0]         count_o
);

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result word shown while busy");

  a_clear_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (kind_i == ole_pkg::KIND_CLEAR)) |=>
      (done_o && (count_o == '0) && (status_o == ole_pkg::ST_OK)))
    else $error("clear did not give an empty list at once");

  a_count_moves_with_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(count_o) |-> done_o)
    else $error("count changed without a result word");

  a_error_no_element: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != ole_pkg::ST_OK)) |-> (element_o == '0))
    else $error("failed request returned a nonzero element");

endmodule

bind ordered_list_engine ole_checker u_chk (.*);
